@@ sv/tls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the three-level task scheduler.
// No dependencies; imported by tls_ctrl, tls_dp and the top level.
package tls_pkg;

    localparam int TLS_TASKS       = 64;
    localparam int TLS_QUEUE_DEPTH = 64;
    localparam int SLOT_W          = 6;

    // command codes
    localparam logic [2:0] CMD_SPAWN   = 3'd0;
    localparam logic [2:0] CMD_PICK    = 3'd1;
    localparam logic [2:0] CMD_SUSPEND = 3'd2;
    localparam logic [2:0] CMD_UNPARK  = 3'd3;
    localparam logic [2:0] CMD_YIELD   = 3'd4;
    localparam logic [2:0] CMD_RESTART = 3'd5;
    localparam logic [2:0] CMD_DONE    = 3'd6;

    // task states
    localparam logic [2:0] TS_FREE      = 3'd0;
    localparam logic [2:0] TS_CREATED   = 3'd1;
    localparam logic [2:0] TS_RUNNABLE  = 3'd2;
    localparam logic [2:0] TS_RUNNING   = 3'd3;
    localparam logic [2:0] TS_SUSPENDED = 3'd4;
    localparam logic [2:0] TS_DONE      = 3'd5;

    // priority classes
    localparam logic [1:0] CLS_URGENT = 2'd0;
    localparam logic [1:0] CLS_NORMAL = 2'd1;
    localparam logic [1:0] CLS_SPARE  = 2'd3;

    // result status
    localparam logic [1:0] RS_OK      = 2'd0;
    localparam logic [1:0] RS_IGNORED = 2'd1;
    localparam logic [1:0] RS_FULL    = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_EXEC   = 4'd2;
    localparam logic [3:0] OP_QSTART = 4'd3;
    localparam logic [3:0] OP_RDQ    = 4'd4;
    localparam logic [3:0] OP_RDS    = 4'd5;
    localparam logic [3:0] OP_DEC    = 4'd6;
    localparam logic [3:0] OP_NEXTQ  = 4'd7;
    localparam logic [3:0] OP_CLN    = 4'd8;
    localparam logic [3:0] OP_INIT   = 4'd9;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [SLOT_W-1:0] task_slot;
        logic [1:0]        prio_class;
        logic [1:0]        wait_reason;
    } sched_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] picked_slot;
        logic              found;
        logic [1:0]        status;
        logic [6:0]        freed_count;
    } sched_out_t;

    typedef struct packed {
        logic [3:0] op;
    } ctl_t;

    typedef struct packed {
        logic req_pick;
        logic loop_more;
        logic q_last;
        logic hit;
        logic sweep_end;
        logic init_last;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/tls_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ sv/tls_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequencer of the task scheduler: steps the datapath through each command.
// Depends on tls_pkg.
module tls_ctrl
    import tls_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire dp_stat_t stat,
    output ctl_t          ctl
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_QSTART = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_RDS    = 4'd5;
    localparam logic [3:0] S_DEC    = 4'd6;
    localparam logic [3:0] S_CLN    = 4'd7;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_NONE;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.op = OP_INIT;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = stat.out_busy;
                if (req_valid && !stat.out_busy)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = stat.req_pick ? S_QSTART : S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.op     = OP_EXEC;
                state_next = S_IDLE;
            end
            S_QSTART:
            begin
                ctl.op     = OP_QSTART;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.loop_more)
                begin
                    ctl.op     = OP_RDQ;
                    state_next = S_RDS;
                end
                else
                begin
                    ctl.op     = OP_NEXTQ;
                    state_next = stat.q_last ? S_CLN : S_QSTART;
                end
            end
            S_RDS:
            begin
                ctl.op     = OP_RDS;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ctl.op     = OP_DEC;
                state_next = stat.hit ? S_IDLE : S_CHK;
            end
            S_CLN:
            begin
                ctl.op = OP_CLN;
                if (stat.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/tls_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the task scheduler: task table, ready queues, result register.
// Depends on tls_pkg and tls_ram.
module tls_dp
    import tls_pkg::*;
#(
    parameter int TASKS       = TLS_TASKS,
    parameter int QUEUE_DEPTH = TLS_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sched_in_t  req,
    input  wire ctl_t       ctl,
    output dp_stat_t        stat,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output sched_out_t      rsp
);

    localparam int TW  = $clog2(TASKS);
    localparam int CW  = $clog2(TASKS + 1);
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(3 * QUEUE_DEPTH);

    function automatic logic [SAW-1:0] store_addr(input logic [1:0] q,
                                                  input logic [PW-1:0] p);
        return SAW'(32'(q) * QUEUE_DEPTH + 32'(p));
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [1:0] cls_map(input logic [1:0] c);
        return (c == CLS_SPARE) ? CLS_NORMAL : c;
    endfunction

    // control registers
    logic [PW-1:0]     head_reg [3];
    logic [PW-1:0]     head_next [3];
    logic [PW-1:0]     tail_reg [3];
    logic [PW-1:0]     tail_next [3];
    logic [FW-1:0]     fill_reg [3];
    logic [FW-1:0]     fill_next [3];
    logic [1:0]        q_reg, q_next;
    logic [FW-1:0]     i_reg, i_next;
    logic [FW-1:0]     limit_reg, limit_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic              run_valid_reg, run_valid_next;
    logic              out_valid_reg, out_valid_next;
    // payload registers
    logic [2:0]        cmd_reg, cmd_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]        cls_reg, cls_next;
    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] e_reg, e_next;
    logic [6:0]        freed_reg, freed_next;
    sched_out_t        out_reg, out_next;

    // task table: {class, state}
    logic          st_we;
    logic [TW-1:0] st_waddr, st_raddr;
    logic [4:0]    st_wdata, st_rdata;
    logic [2:0]    rd_st;
    logic [1:0]    rd_cl;
    // ready store
    logic              sq_we;
    logic [SAW-1:0]    sq_waddr, sq_raddr;
    logic [SLOT_W-1:0] sq_wdata, sq_rdata;

    logic              push_en, push_head, pop_en;
    logic [1:0]        push_q;
    logic [SLOT_W-1:0] push_val;

    // command evaluation
    logic [1:0]        ex_rs, ex_q;
    logic              ex_need_push, ex_front, ex_we, ex_full;
    logic [2:0]        ex_st;
    logic [1:0]        ex_cl;
    logic              run_ok, e_ok, e_skip, hit;

    assign rd_st  = st_rdata[2:0];
    assign rd_cl  = st_rdata[4:3];
    assign run_ok = run_valid_reg && (32'(run_slot_reg) < TASKS);
    assign e_ok   = 32'(e_reg) < TASKS;
    assign hit    = e_ok && (rd_st == TS_CREATED || rd_st == TS_RUNNABLE);
    assign e_skip = !e_ok || rd_st == TS_FREE || rd_st == TS_DONE;

    tls_ram #(.WIDTH(5), .DEPTH(TASKS)) u_task_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tls_ram #(.WIDTH(SLOT_W), .DEPTH(3 * QUEUE_DEPTH)) u_ready_ram (
        .clk   (clk),
        .we    (sq_we),
        .waddr (sq_waddr),
        .wdata (sq_wdata),
        .raddr (sq_raddr),
        .rdata (sq_rdata)
    );

    always_comb
    begin
        ex_rs        = RS_OK;
        ex_q         = CLS_URGENT;
        ex_need_push = 1'b0;
        ex_front     = 1'b0;
        ex_we        = 1'b0;
        ex_st        = rd_st;
        ex_cl        = cls_map(rd_cl);
        case (cmd_reg)
            CMD_SPAWN:
            begin
                if (!ok_reg || rd_st != TS_FREE)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_q         = cls_reg;
                    ex_front     = (cls_reg == CLS_URGENT);
                    ex_need_push = 1'b1;
                    ex_we        = 1'b1;
                    ex_st        = TS_CREATED;
                    ex_cl        = cls_reg;
                end
            end
            CMD_SUSPEND:
            begin
                if (!ok_reg || rd_st == TS_FREE || rd_st == TS_DONE)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_we = 1'b1;
                    ex_st = TS_SUSPENDED;
                end
            end
            CMD_UNPARK:
            begin
                if (!ok_reg || rd_st != TS_SUSPENDED)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_q         = cls_map(rd_cl);
                    ex_need_push = 1'b1;
                    ex_we        = 1'b1;
                    ex_st        = TS_RUNNABLE;
                end
            end
            CMD_YIELD:
            begin
                if (!run_ok || rd_st == TS_FREE || rd_st == TS_DONE)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_q         = cls_map(rd_cl);
                    ex_need_push = 1'b1;
                    ex_we        = 1'b1;
                    ex_st        = TS_RUNNABLE;
                end
            end
            CMD_RESTART:
            begin
                if (!ok_reg || rd_st == TS_FREE)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_q         = cls_map(rd_cl);
                    ex_front     = 1'b1;
                    ex_need_push = 1'b1;
                    ex_we        = 1'b1;
                    ex_st        = TS_CREATED;
                end
            end
            CMD_DONE:
            begin
                if (!ok_reg || rd_st == TS_FREE)
                begin
                    ex_rs = RS_IGNORED;
                end
                else
                begin
                    ex_we = 1'b1;
                    ex_st = TS_DONE;
                end
            end
            default:
            begin
                ex_rs = RS_IGNORED;
            end
        endcase
        ex_full = (fill_reg[ex_q] == FW'(QUEUE_DEPTH));
        // a full queue drops the push and the state change with it
        if (ex_need_push && ex_full)
        begin
            ex_rs = RS_FULL;
            ex_we = 1'b0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            head_next[k] = head_reg[k];
            tail_next[k] = tail_reg[k];
            fill_next[k] = fill_reg[k];
        end
        q_next         = q_reg;
        i_next         = i_reg;
        limit_next     = limit_reg;
        cnt_next       = cnt_reg;
        run_slot_next  = run_slot_reg;
        run_valid_next = run_valid_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        cls_next       = cls_reg;
        ok_next        = ok_reg;
        e_next         = e_reg;
        freed_next     = freed_reg;
        out_next       = out_reg;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        st_raddr       = '0;
        sq_raddr       = '0;
        push_en        = 1'b0;
        push_head      = 1'b0;
        push_q         = CLS_URGENT;
        push_val       = '0;
        pop_en         = 1'b0;

        unique case (ctl.op)
            OP_LOAD:
            begin
                cmd_next   = req.cmd;
                slot_next  = req.task_slot;
                cls_next   = cls_map(req.prio_class);
                ok_next    = 32'(req.task_slot) < TASKS;
                q_next     = CLS_URGENT;
                freed_next = '0;
                st_raddr   = (req.cmd == CMD_YIELD) ? TW'(run_slot_reg) : TW'(req.task_slot);
            end
            OP_EXEC:
            begin
                st_we      = ex_we;
                st_waddr   = (cmd_reg == CMD_YIELD) ? TW'(run_slot_reg) : TW'(slot_reg);
                st_wdata   = {ex_cl, ex_st};
                push_en    = ex_need_push && !ex_full;
                push_head  = ex_front;
                push_q     = ex_q;
                push_val   = (cmd_reg == CMD_YIELD) ? run_slot_reg : slot_reg;
                if (cmd_reg == CMD_YIELD && ex_rs == RS_OK)
                begin
                    run_valid_next = 1'b0;
                end
                out_valid_next = 1'b1;
                out_next       = '{picked_slot: slot_reg, found: 1'b0,
                                   status: ex_rs, freed_count: 7'd0};
            end
            OP_QSTART:
            begin
                // walk no further than the length at the start of this queue
                limit_next = fill_reg[q_reg];
                i_next     = '0;
            end
            OP_RDQ:
            begin
                sq_raddr = store_addr(q_reg, head_reg[q_reg]);
            end
            OP_RDS:
            begin
                e_next   = sq_rdata;
                pop_en   = 1'b1;
                st_raddr = TW'(sq_rdata);
            end
            OP_DEC:
            begin
                i_next = i_reg + 1'b1;
                if (hit)
                begin
                    st_we          = 1'b1;
                    st_waddr       = TW'(e_reg);
                    st_wdata       = {rd_cl, TS_RUNNING};
                    run_slot_next  = e_reg;
                    run_valid_next = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '{picked_slot: e_reg, found: 1'b1,
                                       status: RS_OK, freed_count: 7'd0};
                end
                else if (!e_skip)
                begin
                    // rotate suspended or running entry to the back
                    push_en  = 1'b1;
                    push_q   = q_reg;
                    push_val = e_reg;
                end
            end
            OP_NEXTQ:
            begin
                if (q_reg != 2'd2)
                begin
                    q_next = q_reg + 1'b1;
                end
                cnt_next = '0;
            end
            OP_CLN:
            begin
                // read entry cnt, retire entry cnt-1 from last cycle's read
                st_raddr = TW'(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0 && rd_st == TS_DONE)
                begin
                    st_we      = 1'b1;
                    st_waddr   = TW'(cnt_reg - 1'b1);
                    st_wdata   = {rd_cl, TS_FREE};
                    freed_next = freed_reg + 1'b1;
                end
                if (cnt_reg == CW'(TASKS))
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{picked_slot: slot_reg, found: 1'b0,
                                       status: RS_OK, freed_count: freed_next};
                end
            end
            OP_INIT:
            begin
                st_we    = 1'b1;
                st_waddr = TW'(cnt_reg);
                st_wdata = {CLS_URGENT, TS_FREE};
                cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase

        if (pop_en)
        begin
            head_next[q_reg] = ptr_inc(head_reg[q_reg]);
            fill_next[q_reg] = fill_reg[q_reg] - 1'b1;
        end

        sq_we    = push_en;
        sq_wdata = push_val;
        sq_waddr = store_addr(push_q, tail_reg[push_q]);
        if (push_en)
        begin
            fill_next[push_q] = fill_reg[push_q] + 1'b1;
            if (push_head)
            begin
                head_next[push_q] = ptr_dec(head_reg[push_q]);
                sq_waddr          = store_addr(push_q, ptr_dec(head_reg[push_q]));
            end
            else
            begin
                tail_next[push_q] = ptr_inc(tail_reg[push_q]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                fill_reg[k] <= '0;
            end
            q_reg         <= '0;
            i_reg         <= '0;
            limit_reg     <= '0;
            cnt_reg       <= '0;
            run_slot_reg  <= '0;
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k] <= head_next[k];
                tail_reg[k] <= tail_next[k];
                fill_reg[k] <= fill_next[k];
            end
            q_reg         <= q_next;
            i_reg         <= i_next;
            limit_reg     <= limit_next;
            cnt_reg       <= cnt_next;
            run_slot_reg  <= run_slot_next;
            run_valid_reg <= run_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        slot_reg  <= slot_next;
        cls_reg   <= cls_next;
        ok_reg    <= ok_next;
        e_reg     <= e_next;
        freed_reg <= freed_next;
        out_reg   <= out_next;
    end

    assign stat.req_pick  = (req.cmd == CMD_PICK);
    assign stat.loop_more = (i_reg < limit_reg);
    assign stat.q_last    = (q_reg == 2'd2);
    assign stat.hit       = hit;
    assign stat.sweep_end = (cnt_reg == CW'(TASKS));
    assign stat.init_last = (cnt_reg == CW'(TASKS - 1));
    assign stat.out_busy  = out_valid_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
`default_nettype wire

@@ sv/three_level_task_scheduler_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Three-level strict-priority task scheduler: one result beat per command
// beat. After reset the task table is swept to free, and no command is
// taken until that ends. Commands other than pick are loaded, then executed
// in the EXEC state, and their result beat is registered; as the command
// port stays shut until that beat has gone, a new command is not taken while
// one is still in flight. A pick starts each queue in turn and walks its
// entries (each entry needs a ready-store read followed by a task-table
// read); a pick that finds nothing then sweeps the task table to free done
// tasks. The next command is taken once the result beat has gone.
// Depends on tls_pkg, tls_ctrl, tls_dp and tls_ram.
module three_level_task_scheduler_top
    import tls_pkg::*;
#(
    parameter int TASKS       = TLS_TASKS,
    parameter int QUEUE_DEPTH = TLS_QUEUE_DEPTH
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire sched_in_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output sched_out_t     rsp
);

    ctl_t     ctl;
    dp_stat_t stat;

    tls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    tls_dp #(.TASKS(TASKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    a_no_accept_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !rsp_valid)
        else $error("command beat taken while a result beat is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("command port open right after a command beat");

    a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found) |-> (rsp.status == RS_OK && rsp.freed_count == 7'd0))
        else $error("found pick carries a bad status or freed count");

    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result beat without a command in flight");

endmodule
`default_nettype wire

@@ test/tb_three_level_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the three-level task scheduler: a driver, a monitor and an
// in-bench model of the task table and ready queues. Depends on tls_pkg and the top level.
module tb_three_level_task_scheduler_top;
    import tls_pkg::*;

    localparam int NT = TLS_TASKS;
    localparam int QD = TLS_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 5000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    sched_in_t  req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    sched_out_t rsp;

    three_level_task_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // scheduler state as the bench sees it
    logic [2:0] tstate [NT];
    logic [1:0] tclass [NT];
    logic [5:0] ring [3][QD];
    int         qhead [3];
    int         qtail [3];
    int         qfill [3];
    logic [5:0] run_slot;
    logic       run_valid;

    sched_in_t  cmd_queue [$];
    sched_out_t expected_rsp [$];
    int         errors = 0;
    int         cycles = 0;
    int         hold_off = 0;     // receiver hold-off, counted down in its own process
    bit         stim_done = 1'b0;
    int         gap = 0;

    function automatic logic [1:0] norm_class(logic [1:0] c);
        return (c == CLS_SPARE) ? CLS_NORMAL : c;
    endfunction

    function automatic bit ring_append(int q, logic [5:0] s);
        if (qfill[q] >= QD) return 1'b0;
        ring[q][qtail[q]] = s;
        qtail[q] = (qtail[q] + 1) % QD;
        qfill[q]++;
        return 1'b1;
    endfunction

    function automatic bit ring_prepend(int q, logic [5:0] s);
        if (qfill[q] >= QD) return 1'b0;
        qhead[q] = (qhead[q] + QD - 1) % QD;
        ring[q][qhead[q]] = s;
        qfill[q]++;
        return 1'b1;
    endfunction

    function automatic logic [5:0] ring_take(int q);
        logic [5:0] v;
        v = ring[q][qhead[q]];
        qhead[q] = (qhead[q] + 1) % QD;
        qfill[q]--;
        return v;
    endfunction

    function automatic sched_out_t schedule_cmd(sched_in_t c);
        sched_out_t r;
        logic [1:0] cls;
        logic [5:0] e;
        int lim;
        bit hit;
        r = '0;
        r.picked_slot = c.task_slot;
        r.status = RS_OK;
        cls = norm_class(c.prio_class);
        hit = 1'b0;
        case (c.cmd)
            CMD_SPAWN:
            begin
                if (tstate[c.task_slot] != TS_FREE) r.status = RS_IGNORED;
                else if (!(cls == CLS_URGENT ? ring_prepend(0, c.task_slot)
                                            : ring_append(cls, c.task_slot)))
                    r.status = RS_FULL;
                else
                begin
                    tstate[c.task_slot] = TS_CREATED;
                    tclass[c.task_slot] = cls;
                end
            end
            CMD_PICK:
            begin
                for (int q = 0; q < 3 && !hit; q++)
                begin
                    lim = qfill[q];
                    for (int i = 0; i < lim && qfill[q] != 0 && !hit; i++)
                    begin
                        e = ring_take(q);
                        if (tstate[e] == TS_CREATED || tstate[e] == TS_RUNNABLE)
                        begin
                            tstate[e] = TS_RUNNING;
                            run_slot = e;
                            run_valid = 1'b1;
                            r.picked_slot = e;
                            r.found = 1'b1;
                            hit = 1'b1;
                        end
                        else if (tstate[e] != TS_DONE && tstate[e] != TS_FREE)
                            void'(ring_append(q, e));
                    end
                end
                if (!hit)
                    for (int t = 0; t < NT; t++)
                        if (tstate[t] == TS_DONE)
                        begin
                            tstate[t] = TS_FREE;
                            r.freed_count++;
                        end
            end
            CMD_SUSPEND:
            begin
                if (tstate[c.task_slot] == TS_FREE || tstate[c.task_slot] == TS_DONE)
                    r.status = RS_IGNORED;
                else tstate[c.task_slot] = TS_SUSPENDED;
            end
            CMD_UNPARK:
            begin
                if (tstate[c.task_slot] != TS_SUSPENDED) r.status = RS_IGNORED;
                else if (!ring_append(tclass[c.task_slot], c.task_slot)) r.status = RS_FULL;
                else tstate[c.task_slot] = TS_RUNNABLE;
            end
            CMD_YIELD:
            begin
                if (!run_valid || tstate[run_slot] == TS_FREE || tstate[run_slot] == TS_DONE)
                    r.status = RS_IGNORED;
                else if (!ring_append(tclass[run_slot], run_slot)) r.status = RS_FULL;
                else
                begin
                    tstate[run_slot] = TS_RUNNABLE;
                    run_valid = 1'b0;
                end
            end
            CMD_RESTART:
            begin
                if (tstate[c.task_slot] == TS_FREE) r.status = RS_IGNORED;
                else if (!ring_prepend(tclass[c.task_slot], c.task_slot)) r.status = RS_FULL;
                else tstate[c.task_slot] = TS_CREATED;
            end
            CMD_DONE:
            begin
                if (tstate[c.task_slot] == TS_FREE) r.status = RS_IGNORED;
                else tstate[c.task_slot] = TS_DONE;
            end
            default: r.status = RS_IGNORED;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    task automatic add_cmd(sched_in_t x);
        cmd_queue.insert(cmd_queue.size(), x);
    endtask

    function automatic int short_or_long_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // driver: offer the next command, hold it while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.insert(expected_rsp.size(), schedule_cmd(req));
                cmd_queue.delete(0);
                gap = short_or_long_gap();
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (req_valid && req_stall)
                ;   // hold the beat
            else if (gap > 0)
            begin
                gap--;
                req_valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                req_valid <= 1'b1;
                req <= cmd_queue[0];
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor: compare each result beat, drive random receiver stall
    always @(posedge clk)
    begin
        sched_out_t w;
        cycles++;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    w = expected_rsp[0];
                    expected_rsp.delete(0);
                    if (rsp.picked_slot !== w.picked_slot)
                        report_mismatch("picked_slot", rsp.picked_slot, w.picked_slot);
                    if (rsp.found !== w.found) report_mismatch("found", rsp.found, w.found);
                    if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
                    if (rsp.freed_count !== w.freed_count)
                        report_mismatch("freed_count", rsp.freed_count, w.freed_count);
                end
            end
            if (hold_off > 0)
                rsp_stall <= 1'b1;
            else if (rsp_valid && rsp_stall)
                rsp_stall <= ($urandom_range(0, 2) == 0);
            else
                rsp_stall <= ($urandom_range(0, 4) == 0);
        end
    end

    // receiver hold-off: count the stalled cycles, now and then start a short one
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
        else if (rst_n && $urandom_range(0, 59) == 0)
            hold_off <= $urandom_range(5, 30);
    end

    function automatic sched_in_t mk(logic [2:0] c, logic [5:0] s, logic [1:0] p,
                                     logic [1:0] w);
        sched_in_t x;
        x.cmd = c;
        x.task_slot = s;
        x.prio_class = p;
        x.wait_reason = w;
        return x;
    endfunction

    function automatic sched_in_t rand_cmd();
        sched_in_t x;
        int k;
        x.task_slot = 6'($urandom_range(0, 63));
        x.prio_class = 2'($urandom_range(0, 3));
        x.wait_reason = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 99);
        // weight towards a lively mix of spawns and picks
        if (k < 30) x.cmd = CMD_SPAWN;
        else if (k < 55) x.cmd = CMD_PICK;
        else if (k < 99) x.cmd = 3'($urandom_range(2, 6));
        else x.cmd = 3'd7;
        if ($urandom_range(0, 1)) x.task_slot = 6'($urandom_range(0, 15));
        return x;
    endfunction

    initial
    begin
        for (int t = 0; t < NT; t++)
        begin
            tstate[t] = TS_FREE;
            tclass[t] = CLS_URGENT;
        end
        for (int q = 0; q < 3; q++)
        begin
            qhead[q] = 0;
            qtail[q] = 0;
            qfill[q] = 0;
        end
        run_slot = '0;
        run_valid = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every command, wrong states, class three, empty pick, unused code
        add_cmd(mk(CMD_PICK, 6'd63, 2'd3, 2'd3));
        add_cmd(mk(CMD_YIELD, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_SPAWN, 6'd0, CLS_URGENT, 2'd0));
        add_cmd(mk(CMD_SPAWN, 6'd63, 2'd2, 2'd0));
        add_cmd(mk(CMD_SPAWN, 6'd5, CLS_SPARE, 2'd0));
        add_cmd(mk(CMD_SPAWN, 6'd5, CLS_NORMAL, 2'd0));
        add_cmd(mk(CMD_UNPARK, 6'd5, 2'd0, 2'd0));
        add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_SUSPEND, 6'd5, 2'd0, 2'd3));
        add_cmd(mk(CMD_UNPARK, 6'd5, 2'd0, 2'd0));
        add_cmd(mk(CMD_YIELD, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_RESTART, 6'd63, 2'd0, 2'd0));
        add_cmd(mk(CMD_RESTART, 6'd20, 2'd0, 2'd0));
        add_cmd(mk(CMD_DONE, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_SUSPEND, 6'd0, 2'd0, 2'd1));
        add_cmd(mk(CMD_DONE, 6'd30, 2'd0, 2'd0));
        add_cmd(mk(3'd7, 6'd42, 2'd1, 2'd2));
        for (int i = 0; i < 4; i++) add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_DONE, 6'd5, 2'd0, 2'd0));
        add_cmd(mk(CMD_DONE, 6'd63, 2'd0, 2'd0));
        add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));

        // fill a queue until it reports full via repeated restarts
        for (int i = 0; i < 70; i++)
            add_cmd(mk(CMD_SPAWN, 6'(i), CLS_URGENT, 2'd0));
        for (int i = 0; i < 8; i++) add_cmd(mk(CMD_RESTART, 6'd1, 2'd0, 2'd0));
        for (int i = 0; i < 64; i++) add_cmd(mk(CMD_DONE, 6'(i), 2'd0, 2'd0));
        add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));
        add_cmd(mk(CMD_PICK, 6'd0, 2'd0, 2'd0));

        // long receiver hold-off with the sender still offering
        wait (cmd_queue.size() < 150);
        @(negedge clk);
        hold_off = 200;
        for (int i = 0; i < 900; i++) add_cmd(rand_cmd());

        // sender pause until everything is back
        wait (cmd_queue.size() == 0);
        wait (expected_rsp.size() == 0 && !req_valid);
        for (int i = 0; i < 100; i++) add_cmd(rand_cmd());
        wait (cmd_queue.size() == 0);
        wait (expected_rsp.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
sv/tls_pkg.sv
sv/tls_ram.sv
sv/tls_ctrl.sv
sv/tls_dp.sv
sv/three_level_task_scheduler_top.sv
test/tb_three_level_task_scheduler_top.sv
